// File: design/ppp_pkg.sv
// Shared widths, types, register codes and helpers of the pinhole point projector.
package ppp_pkg;

    // Sizing
    localparam int COORD_BITS = 24;
    localparam int MAX_DIM    = 4096;

    localparam int CB   = COORD_BITS;
    localparam int DB   = CB - 1;                   // positive depth magnitude
    localparam int FB   = 22;                       // focal length width
    localparam int CXB  = 20;                       // principal point width
    localparam int DIMB = 13;                       // image size register width
    localparam int PB   = FB + CB;                  // |focal * camera coordinate|
    localparam int QB   = $clog2(MAX_DIM) + 10;     // quotient bits kept
    localparam int HB   = PB - QB;                  // dividend bits above the quotient
    localparam int CW   = (HB > CB) ? HB : CB;      // overflow compare width
    localparam int RW   = CB;                       // divider remainder width
    localparam int SB   = QB + 3;                   // signed pixel coordinate, 1/256 px
    localparam int CLB  = $clog2(MAX_DIM);          // pixel index width
    localparam int DMB  = $clog2(MAX_DIM + 1);      // clamped image size width
    localparam int AW   = CLB + DMB;                // full pixel address width

    localparam int COLB  = 12;
    localparam int ADDRB = 24;
    localparam int INB   = ((3 * CB + 24 + 7) / 8) * 8;
    localparam int OUTB  = 2 * COLB + ADDRB + 24;

    localparam int QDEPTH = 4;
    localparam int QAB    = $clog2(QDEPTH);

    // Configuration port
    localparam int CIB = 3;
    localparam logic [CIB-1:0] CFG_FOCAL_X      = 3'd0;
    localparam logic [CIB-1:0] CFG_FOCAL_Y      = 3'd1;
    localparam logic [CIB-1:0] CFG_CENTER_X     = 3'd2;
    localparam logic [CIB-1:0] CFG_CENTER_Y     = 3'd3;
    localparam logic [CIB-1:0] CFG_IMAGE_WIDTH  = 3'd4;
    localparam logic [CIB-1:0] CFG_IMAGE_HEIGHT = 3'd5;

    localparam logic [FB-1:0]   FOCAL_X_RST  = 22'd380084;
    localparam logic [FB-1:0]   FOCAL_Y_RST  = 22'd378127;
    localparam logic [CXB-1:0]  CENTER_X_RST = 20'd110782;
    localparam logic [CXB-1:0]  CENTER_Y_RST = 20'd105565;
    localparam logic [DIMB-1:0] WIDTH_RST    = 13'd1024;
    localparam logic [DIMB-1:0] HEIGHT_RST   = 13'd768;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_color;

    // Geometry used by the back end
    typedef struct packed {
        logic [CXB-1:0]  center_x;
        logic [CXB-1:0]  center_y;
        logic [DIMB-1:0] width;
        logic [DIMB-1:0] height;
    } t_geom;

    // Front end first stage: rotated point as sign and magnitude
    typedef struct packed {
        logic          depth_ok;
        logic [DB-1:0] den;
        logic [CB-1:0] u_mag;
        logic          u_neg;
        logic [CB-1:0] v_mag;
        logic          v_neg;
        t_color        color;
    } t_point;

    // Queue entry: products and depth ready for division
    typedef struct packed {
        logic          depth_ok;
        logic [DB-1:0] den;
        logic [PB-1:0] pu_mag;
        logic          pu_neg;
        logic [PB-1:0] pv_mag;
        logic          pv_neg;
        t_color        color;
    } t_item;

    // Side data traveling beside the dividers
    typedef struct packed {
        logic   depth_ok;
        logic   pu_neg;
        logic   pv_neg;
        t_color color;
    } t_side;

    typedef struct packed {
        logic              hit;
        logic [COLB-1:0]   column;
        logic [COLB-1:0]   row;
        logic [ADDRB-1:0]  addr;
        t_color            color;
    } t_result;

    // floor(P/d) from sign and unsigned quotient, plus principal point (1/256 px)
    function automatic logic [SB-1:0] ppp_fixed_coord(
        input logic [QB-1:0]  quo,
        input logic           rem_nz,
        input logic           neg,
        input logic [CXB-1:0] center
    );
        logic [SB-1:0] mag;
        logic [SB-1:0] sgn;
        mag = neg ? (SB'(quo) + SB'(rem_nz)) : SB'(quo);
        sgn = neg ? (~mag + SB'(1)) : mag;
        return sgn + SB'(center);
    endfunction

    // Integer pixel index is the top part of the fixed coordinate; check it against the size
    function automatic logic ppp_in_range(
        input logic [SB-1:0]  coord,
        input logic [DMB-1:0] size
    );
        logic [SB-9:0] pix;
        pix = coord[SB-1:8];
        return !pix[SB-9] && (pix < (SB-8)'(size));
    endfunction

    // Image size saturated to MAX_DIM
    function automatic logic [DMB-1:0] ppp_clamp_dim(input logic [DIMB-1:0] d);
        return ({1'b0, d} > (DIMB+1)'(MAX_DIM)) ? DMB'(MAX_DIM) : DMB'(d);
    endfunction

endpackage

// File: design/ppp_front.sv
// Front end: accepts points, rotates into the camera frame and forms the numerators.
module ppp_front import ppp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [CB-1:0] i_laser_x,
    input  logic [CB-1:0] i_laser_y,
    input  logic [CB-1:0] i_laser_z,
    input  t_color        i_color,
    input  logic [FB-1:0] i_focal_x,
    input  logic [FB-1:0] i_focal_y,
    output logic          o_push,
    input  logic          i_push_ready,
    output t_item         o_item
);

    logic   r_s1_vld;
    t_point r_s1;
    logic   r_s2_vld;
    t_item  r_s2;

    logic   w_ce;
    t_point w_pt;
    logic [PB-1:0] w_pu;
    logic [PB-1:0] w_pv;

    // Both stages advance together unless the queue refuses a held item
    assign w_ce    = !r_s2_vld || i_push_ready;
    assign o_ready = w_ce;
    assign o_push  = r_s2_vld && i_push_ready;
    assign o_item  = r_s2;

    // Rotation: camera x = -y, camera y = -z, depth = x; kept as sign and magnitude
    always_comb begin
        w_pt.depth_ok = !i_laser_x[CB-1] && (i_laser_x != '0);
        w_pt.den      = i_laser_x[DB-1:0];
        w_pt.u_neg    = !i_laser_y[CB-1] && (i_laser_y != '0);
        w_pt.u_mag    = i_laser_y[CB-1] ? (~i_laser_y + CB'(1)) : i_laser_y;
        w_pt.v_neg    = !i_laser_z[CB-1] && (i_laser_z != '0);
        w_pt.v_mag    = i_laser_z[CB-1] ? (~i_laser_z + CB'(1)) : i_laser_z;
        w_pt.color    = i_color;
    end

    // Focal length times camera coordinate magnitude
    assign w_pu = i_focal_x * r_s1.u_mag;
    assign w_pv = i_focal_y * r_s1.v_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (w_ce) begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_s1          <= w_pt;
            r_s2.depth_ok <= r_s1.depth_ok;
            r_s2.den      <= r_s1.den;
            r_s2.pu_mag   <= w_pu;
            r_s2.pu_neg   <= r_s1.u_neg;
            r_s2.pv_mag   <= w_pv;
            r_s2.pv_neg   <= r_s1.v_neg;
            r_s2.color    <= r_s1.color;
        end
    end

endmodule

// File: design/ppp_queue.sv
// Small register queue decoupling the front end from the division pipeline.
module ppp_queue import ppp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_not_full,
    input  logic  i_pop,
    output logic  o_not_empty,
    output t_item o_item
);

    t_item            r_mem [0:QDEPTH-1];
    logic [QAB-1:0]   r_wr_ptr;
    logic [QAB-1:0]   r_rd_ptr;
    logic [QAB:0]     r_count;

    assign o_not_full  = (r_count != (QAB+1)'(QDEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_item      = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + QAB'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + QAB'(1);
            if (i_push && !i_pop)      r_count <= r_count + (QAB+1)'(1);
            else if (!i_push && i_pop) r_count <= r_count - (QAB+1)'(1);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_item;
    end

endmodule

// File: design/ppp_div.sv
// One lane of the pipelined restoring divider, one quotient bit per stage.
module ppp_div import ppp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_ce,
    input  logic [PB-1:0] i_num,
    input  logic [DB-1:0] i_den,
    output logic          o_ovf,
    output logic [QB-1:0] o_quo,
    output logic          o_rem_nz
);

    logic [DB-1:0] r_den [0:QB-1];
    logic [RW-1:0] r_rem [0:QB];
    logic [QB-1:0] r_quo [0:QB];
    logic [QB-1:0] r_low [0:QB-1];
    logic          r_ovf [0:QB];

    logic [CW-1:0] w_high;
    logic          w_ovf;

    // Quotient does not fit in QB bits when the upper dividend part reaches the divisor
    assign w_high = CW'(i_num[PB-1:QB]);
    assign w_ovf  = (w_high >= CW'(i_den));

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_den[0] <= i_den;
            r_rem[0] <= w_high[RW-1:0];
            r_low[0] <= i_num[QB-1:0];
            r_quo[0] <= '0;
            r_ovf[0] <= w_ovf;
        end
    end

    // Each stage shifts in one dividend bit and tries one subtraction
    for (genvar g = 0; g < QB; g++) begin : g_stage
        logic [RW-1:0] w_trial;
        logic          w_fits;

        assign w_trial = {r_rem[g][RW-2:0], r_low[g][QB-1]};
        assign w_fits  = (w_trial >= RW'(r_den[g]));

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[g+1] <= w_fits ? (w_trial - RW'(r_den[g])) : w_trial;
                r_quo[g+1] <= {r_quo[g][QB-2:0], w_fits};
                r_ovf[g+1] <= r_ovf[g];
            end
        end

        if (g < QB - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_den[g+1] <= r_den[g];
                    r_low[g+1] <= {r_low[g][QB-2:0], 1'b0};
                end
            end
        end
    end

    assign o_ovf    = r_ovf[QB];
    assign o_quo    = r_quo[QB];
    assign o_rem_nz = (r_rem[QB] != '0);

endmodule

// File: design/ppp_back.sv
// Back end: divides both numerators by depth, checks the image bounds and forms the result.
module ppp_back import ppp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_geom   i_geom,
    input  logic    i_q_valid,
    input  t_item   i_q_item,
    output logic    o_q_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic          r_sb_vld [0:QB];
    t_side         r_sb     [0:QB];

    logic          r_a_vld;
    logic          r_a_hit;
    logic [CLB-1:0] r_a_col;
    logic [CLB-1:0] r_a_row;
    t_color        r_a_color;

    logic          r_out_vld;
    t_result       r_out;

    logic          w_ce;
    logic          w_u_ovf;
    logic          w_v_ovf;
    logic [QB-1:0] w_u_quo;
    logic [QB-1:0] w_v_quo;
    logic          w_u_nz;
    logic          w_v_nz;
    logic [SB-1:0] w_u_fix;
    logic [SB-1:0] w_v_fix;
    logic [DMB-1:0] w_wc;
    logic [DMB-1:0] w_hc;
    logic          w_hit;
    logic [AW-1:0] w_addr;
    t_side         w_side_in;

    // Whole back end moves whenever the output register is free or drained
    assign w_ce     = !r_out_vld || i_ready;
    assign o_q_pop  = w_ce && i_q_valid;
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    // Division lanes for column and row
    ppp_div u_div_u (
        .i_clk    (i_clk),
        .i_ce     (w_ce),
        .i_num    (i_q_item.pu_mag),
        .i_den    (i_q_item.den),
        .o_ovf    (w_u_ovf),
        .o_quo    (w_u_quo),
        .o_rem_nz (w_u_nz)
    );

    ppp_div u_div_v (
        .i_clk    (i_clk),
        .i_ce     (w_ce),
        .i_num    (i_q_item.pv_mag),
        .i_den    (i_q_item.den),
        .o_ovf    (w_v_ovf),
        .o_quo    (w_v_quo),
        .o_rem_nz (w_v_nz)
    );

    // Side data delay line matching the divider latency
    always_comb begin
        w_side_in.depth_ok = i_q_item.depth_ok;
        w_side_in.pu_neg   = i_q_item.pu_neg;
        w_side_in.pv_neg   = i_q_item.pv_neg;
        w_side_in.color    = i_q_item.color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= QB; i++) r_sb_vld[i] <= 1'b0;
        end else if (w_ce) begin
            r_sb_vld[0] <= i_q_valid;
            for (int i = 0; i < QB; i++) r_sb_vld[i+1] <= r_sb_vld[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_sb[0] <= w_side_in;
            for (int i = 0; i < QB; i++) r_sb[i+1] <= r_sb[i];
        end
    end

    // Floor quotient plus principal point, then bounds check
    assign w_u_fix = ppp_fixed_coord(w_u_quo, w_u_nz, r_sb[QB].pu_neg, i_geom.center_x);
    assign w_v_fix = ppp_fixed_coord(w_v_quo, w_v_nz, r_sb[QB].pv_neg, i_geom.center_y);
    assign w_wc    = ppp_clamp_dim(i_geom.width);
    assign w_hc    = ppp_clamp_dim(i_geom.height);
    assign w_hit   = r_sb[QB].depth_ok && !w_u_ovf && !w_v_ovf
                     && ppp_in_range(w_u_fix, w_wc) && ppp_in_range(w_v_fix, w_hc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_ce) begin
            r_a_vld <= r_sb_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_a_hit   <= w_hit;
            r_a_col   <= w_hit ? w_u_fix[CLB+7:8] : '0;
            r_a_row   <= w_hit ? w_v_fix[CLB+7:8] : '0;
            r_a_color <= w_hit ? r_sb[QB].color : '0;
        end
    end

    // Linear pixel address and output register
    assign w_addr = AW'(r_a_row) * AW'(w_wc) + AW'(r_a_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ce) begin
            r_out_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_out.hit    <= r_a_hit;
            r_out.column <= COLB'(r_a_col);
            r_out.row    <= COLB'(r_a_row);
            r_out.addr   <= r_a_hit ? ADDRB'(w_addr) : '0;
            r_out.color  <= r_a_color;
        end
    end

endmodule

// File: design/pinhole_point_projector.sv
// Pinhole point projector: a point passes from input transfer to result through two front
// stages, a queue register, a 23-stage divider pipeline and two result stages. Throughput is
// one point per cycle while the result stream is not stalled; the divider lanes then take a
// new point every cycle. Synchronous active-low reset empties the pipeline and queue and
// loads the camera registers with their default intrinsics and a 1024 x 768 image.
module pinhole_point_projector import ppp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Configuration writes
    input  logic             i_cfg_we,
    input  logic [CIB-1:0]   i_cfg_index,
    input  logic [FB-1:0]    i_cfg_data,
    // Point input
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [INB-1:0]   s_axis_tdata,   // laser_x, laser_y, laser_z, red, green, blue
    // Projection result
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUTB-1:0]  m_axis_tdata,   // column, row, pixel_address, red, green, blue
    output logic             m_axis_tuser    // hit
);

    logic [FB-1:0]   r_focal_x;
    logic [FB-1:0]   r_focal_y;
    logic [CXB-1:0]  r_center_x;
    logic [CXB-1:0]  r_center_y;
    logic [DIMB-1:0] r_width;
    logic [DIMB-1:0] r_height;

    t_color  w_color_in;
    t_geom   w_geom;
    logic    w_push;
    logic    w_push_ready;
    t_item   w_push_item;
    logic    w_q_valid;
    logic    w_q_pop;
    t_item   w_q_item;
    t_result w_result;

    // Camera registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= FOCAL_X_RST;
            r_focal_y  <= FOCAL_Y_RST;
            r_center_x <= CENTER_X_RST;
            r_center_y <= CENTER_Y_RST;
            r_width    <= WIDTH_RST;
            r_height   <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FOCAL_X:      r_focal_x  <= i_cfg_data;
                CFG_FOCAL_Y:      r_focal_y  <= i_cfg_data;
                CFG_CENTER_X:     r_center_x <= i_cfg_data[CXB-1:0];
                CFG_CENTER_Y:     r_center_y <= i_cfg_data[CXB-1:0];
                CFG_IMAGE_WIDTH:  r_width    <= i_cfg_data[DIMB-1:0];
                CFG_IMAGE_HEIGHT: r_height   <= i_cfg_data[DIMB-1:0];
                default: ;
            endcase
        end
    end

    assign w_color_in.red   = s_axis_tdata[3*CB +: 8];
    assign w_color_in.green = s_axis_tdata[3*CB+8 +: 8];
    assign w_color_in.blue  = s_axis_tdata[3*CB+16 +: 8];

    assign w_geom.center_x = r_center_x;
    assign w_geom.center_y = r_center_y;
    assign w_geom.width    = r_width;
    assign w_geom.height   = r_height;

    ppp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_laser_x    (s_axis_tdata[0 +: CB]),
        .i_laser_y    (s_axis_tdata[CB +: CB]),
        .i_laser_z    (s_axis_tdata[2*CB +: CB]),
        .i_color      (w_color_in),
        .i_focal_x    (r_focal_x),
        .i_focal_y    (r_focal_y),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_item       (w_push_item)
    );

    ppp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_item      (w_push_item),
        .o_not_full  (w_push_ready),
        .i_pop       (w_q_pop),
        .o_not_empty (w_q_valid),
        .o_item      (w_q_item)
    );

    ppp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (w_geom),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (w_result)
    );

    // Result packing, lowest field first
    assign m_axis_tdata = {w_result.color.blue, w_result.color.green, w_result.color.red,
                           w_result.addr, w_result.row, w_result.column};
    assign m_axis_tuser = w_result.hit;

endmodule

// File: test/tb_pinhole_point_projector.sv
// Testbench of the pinhole point projector: directed and random points against a projector model.
module tb_pinhole_point_projector import ppp_pkg::*;;

    localparam int IDLE_LIMIT = 2000;     // cycles without any transfer before giving up
    localparam int TAIL_CYCLES = 40;      // pipeline is 28 deep
    localparam longint LAT_MAX = 64'sd8388608;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    logic [CIB-1:0]   i_cfg_index   = CFG_FOCAL_X;
    logic [FB-1:0]    i_cfg_data    = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [INB-1:0]   s_axis_tdata  = '0;   // laser_x, laser_y, laser_z, red, green, blue
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUTB-1:0]  m_axis_tdata;         // column, row, pixel_address, red, green, blue
    logic             m_axis_tuser;         // hit

    pinhole_point_projector DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Camera registers as the block should hold them
    logic [FB-1:0]   cam_fx = FOCAL_X_RST;
    logic [FB-1:0]   cam_fy = FOCAL_Y_RST;
    logic [CXB-1:0]  cam_cx = CENTER_X_RST;
    logic [CXB-1:0]  cam_cy = CENTER_Y_RST;
    logic [DIMB-1:0] cam_w  = WIDTH_RST;
    logic [DIMB-1:0] cam_h  = HEIGHT_RST;

    t_result pending_pixels[$];
    t_result want_px, got_px;

    int items_sent    = 0;
    int results_seen  = 0;
    int hits_seen     = 0;
    int errors        = 0;
    int settings_used = 1;
    int idle_cycles   = 0;
    int burst_left    = 0;
    int gap_len       = 0;

    // Receiver stall pattern state
    int rx_mode   = 0;
    int rx_left   = 0;
    int rx_period = 1;
    int rx_duty   = 1;
    int rx_phase  = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Image size saturated at the largest supported dimension
    function automatic longint dim_limit(input logic [DIMB-1:0] d);
        return (d > MAX_DIM) ? longint'(MAX_DIM) : longint'(d);
    endfunction

    function automatic longint floor_quot(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    // Expected pixel for one point under the current camera registers
    function automatic t_result project_point(input logic [INB-1:0] pt);
        longint depth, camx, camy, den, col, row, w, h;
        t_result res;
        res   = '0;
        depth = longint'($signed(pt[23:0]));
        camx  = -longint'($signed(pt[47:24]));
        camy  = -longint'($signed(pt[71:48]));
        w     = dim_limit(cam_w);
        h     = dim_limit(cam_h);
        if (depth <= 0)
            return res;
        den = depth * 256;
        col = floor_quot(longint'(cam_fx) * camx + longint'(cam_cx) * depth, den);
        row = floor_quot(longint'(cam_fy) * camy + longint'(cam_cy) * depth, den);
        if (col < 0 || row < 0 || col >= w || row >= h)
            return res;
        res.hit         = 1'b1;
        res.column      = col[COLB-1:0];
        res.row         = row[COLB-1:0];
        res.addr        = ADDRB'(row * w + col);
        res.color.red   = pt[79:72];
        res.color.green = pt[87:80];
        res.color.blue  = pt[95:88];
        return res;
    endfunction

    function automatic logic [INB-1:0] pack_point(
        input longint x, input longint y, input longint z,
        input logic [7:0] r, input logic [7:0] g, input logic [7:0] b
    );
        return {b, g, r, CB'(z), CB'(y), CB'(x)};
    endfunction

    // Laser lateral coordinate that lands near a chosen pixel at the given depth
    function automatic logic [CB-1:0] aim_lateral(
        input longint target_px, input longint center, input longint focal, input longint depth
    );
        longint lat;
        if (focal == 0)
            return CB'($urandom);
        lat = ((target_px * 256 + longint'($urandom_range(0, 255)) - center) * depth) / focal;
        if (lat > LAT_MAX)
            lat = LAT_MAX;
        if (lat < -(LAT_MAX - 1))
            lat = -(LAT_MAX - 1);
        return CB'(-lat);   // camera axes point opposite to the laser axes
    endfunction

    task automatic log_error(input string what, input t_result want, input t_result got);
        errors++;
        if (errors <= 10) begin
            $display("%s at %0t: want hit=%0b col=%0d row=%0d addr=%0d rgb=%02h%02h%02h",
                     what, $realtime,
                     want.hit, want.column, want.row, want.addr,
                     want.color.red, want.color.green, want.color.blue);
            $display("    got hit=%0b col=%0d row=%0d addr=%0d rgb=%02h%02h%02h",
                     got.hit, got.column, got.row, got.addr,
                     got.color.red, got.color.green, got.color.blue);
        end
    endtask

    // One point transfer; sender idles in bursts with random gaps
    task automatic send_point(input logic [INB-1:0] pt);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_len    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap_len > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap_len) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pt;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_pixels.push_back(project_point(pt));
        items_sent++;
        @(negedge i_clk);
    endtask

    // Hold the sender until every expected pixel has come back
    task automatic wait_idle;
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_pixels.size() != 0);
    endtask

    task automatic write_reg(input logic [CIB-1:0] idx, input logic [FB-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_FOCAL_X:      cam_fx = val;
            CFG_FOCAL_Y:      cam_fy = val;
            CFG_CENTER_X:     cam_cx = val[CXB-1:0];
            CFG_CENTER_Y:     cam_cy = val[CXB-1:0];
            CFG_IMAGE_WIDTH:  cam_w  = val[DIMB-1:0];
            CFG_IMAGE_HEIGHT: cam_h  = val[DIMB-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Drain, then load all six camera registers; junk above the center and size fields checks masking
    task automatic set_camera(
        input logic [FB-1:0] fx, input logic [FB-1:0] fy,
        input logic [CXB-1:0] cx, input logic [CXB-1:0] cy,
        input logic [DIMB-1:0] w, input logic [DIMB-1:0] h
    );
        wait_idle();
        write_reg(CFG_FOCAL_X, fx);
        write_reg(CFG_FOCAL_Y, fy);
        write_reg(CFG_CENTER_X, {2'($urandom), cx});
        write_reg(CFG_CENTER_Y, {2'($urandom), cy});
        write_reg(CFG_IMAGE_WIDTH, {9'($urandom), w});
        write_reg(CFG_IMAGE_HEIGHT, {9'($urandom), h});
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly points aimed at or just around the image, plus noise and bad depths
    task automatic run_projection_phase(input int count);
        longint depth, w_span, h_span;
        int kind, k;
        logic [CB-1:0] lx, ly, lz;
        repeat (count) begin
            kind  = $urandom_range(0, 99);
            k     = $urandom_range(0, 23);
            depth = 1 + ($urandom % (32'd1 << k));
            if (depth > LAT_MAX - 1)
                depth = LAT_MAX - 1;
            w_span = (cam_w == 0) ? 8 : dim_limit(cam_w);
            h_span = (cam_h == 0) ? 8 : dim_limit(cam_h);
            lx = CB'(depth);
            ly = aim_lateral(longint'($urandom_range(0, int'(w_span) + 7)) - 4,
                             longint'(cam_cx), longint'(cam_fx), depth);
            lz = aim_lateral(longint'($urandom_range(0, int'(h_span) + 7)) - 4,
                             longint'(cam_cy), longint'(cam_fy), depth);
            if (kind >= 70 && kind < 85) begin
                lx = CB'($urandom);
                ly = CB'($urandom);
                lz = CB'($urandom);
            end else if (kind >= 85) begin
                lx = ($urandom_range(0, 4) == 0) ? '0 : CB'(-depth);
            end
            send_point(pack_point(longint'(lx), longint'(ly), longint'(lz),
                                  8'($urandom), 8'($urandom), 8'($urandom)));
        end
    endtask

    // Reset intrinsics: bad depths, principal point, far corners, color extremes
    task automatic test_reset_camera;
        send_point(pack_point(0, 100, -100, 8'hFF, 8'hFF, 8'hFF));
        send_point(pack_point(-1, 0, 0, 8'hAA, 8'h55, 8'hAA));
        send_point(pack_point(-8388608, 0, 0, 8'h01, 8'h02, 8'h03));
        send_point(pack_point(1024, 0, 0, 8'h12, 8'h34, 8'h56));
        send_point(pack_point(8388607, 0, 0, 8'hFF, 8'hFF, 8'hFF));
        send_point(pack_point(1, 0, 0, 8'h00, 8'h00, 8'h00));
        send_point(pack_point(1, 8388607, 0, 8'h80, 8'h7F, 8'h80));
        send_point(pack_point(8388607, -8388608, -8388608, 8'hC3, 8'h3C, 8'hC3));
        send_point(pack_point(8388607, 8388607, 8388607, 8'h0F, 8'hF0, 8'h0F));
        send_point(pack_point(4096, -1000, 500, 8'h9A, 8'hBC, 8'hDE));
    endtask

    // Unit focal, zero principal point: column = floor(camx / depth), exact edges
    task automatic test_image_edges;
        set_camera(22'd256, 22'd256, '0, '0, 13'd640, 13'd480);
        send_point(pack_point(1, 0, 0, 8'h11, 8'h22, 8'h33));
        send_point(pack_point(1, -639, -479, 8'h44, 8'h55, 8'h66));
        send_point(pack_point(1, -640, 0, 8'h77, 8'h88, 8'h99));
        send_point(pack_point(1, 0, -480, 8'hAA, 8'hBB, 8'hCC));
        send_point(pack_point(1, 1, 0, 8'hDD, 8'hEE, 8'hFF));
        send_point(pack_point(2, 1, 0, 8'h01, 8'h01, 8'h01));     // floor of -1/2 is -1
        send_point(pack_point(2, -1, -1, 8'h02, 8'h02, 8'h02));
        send_point(pack_point(3, -5, -7, 8'h03, 8'h03, 8'h03));
        // oversized image saturates at the largest dimension
        set_camera(22'd256, 22'd256, '0, '0, 13'd8191, 13'd8191);
        send_point(pack_point(1, -4095, -4095, 8'hFF, 8'h00, 8'hFF));
        send_point(pack_point(1, -4096, 0, 8'h00, 8'hFF, 8'h00));
        // zero width image takes nothing
        set_camera(22'd256, 22'd256, '0, '0, 13'd0, 13'd5);
        send_point(pack_point(1, 0, 0, 8'h5A, 8'h5A, 8'h5A));
    endtask

    task automatic test_random_sweep;
        set_camera(FOCAL_X_RST, FOCAL_Y_RST, CENTER_X_RST, CENTER_Y_RST, WIDTH_RST, HEIGHT_RST);
        run_projection_phase(250);
        set_camera(22'h3FFFFF, 22'h3FFFFF, 20'hFFFFF, 20'hFFFFF, 13'd4096, 13'd4096);
        run_projection_phase(150);
        set_camera('0, '0, '0, '0, 13'd1, 13'd1);
        run_projection_phase(120);
        set_camera(FB'($urandom_range(64, 1 << 20)), FB'($urandom_range(64, 1 << 20)),
                   CXB'($urandom), CXB'($urandom), 13'd8191, 13'd8191);
        run_projection_phase(150);
        repeat (6) begin
            set_camera(
                ($urandom_range(0, 1) == 0) ? FB'($urandom) : FB'($urandom_range(64, 1 << 20)),
                ($urandom_range(0, 1) == 0) ? FB'($urandom) : FB'($urandom_range(64, 1 << 20)),
                CXB'($urandom), CXB'($urandom),
                ($urandom_range(0, 5) == 0) ? DIMB'($urandom) : DIMB'($urandom_range(1, 640)),
                ($urandom_range(0, 5) == 0) ? DIMB'($urandom) : DIMB'($urandom_range(1, 640)));
            run_projection_phase(145);
        end
    endtask

    // Receiver: stretches of always-ready, random stalls, or a periodic pattern
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode   = $urandom_range(0, 2);
            rx_left   = $urandom_range(20, 150);
            rx_period = $urandom_range(2, 8);
            rx_duty   = $urandom_range(1, rx_period - 1);
        end
        rx_left--;
        rx_phase = (rx_phase + 1) % rx_period;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= (rx_phase < rx_duty);
        endcase
    end

    // Result check against the oldest expected pixel
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got_px.hit         = m_axis_tuser;
            got_px.column      = m_axis_tdata[11:0];
            got_px.row         = m_axis_tdata[23:12];
            got_px.addr        = m_axis_tdata[47:24];
            got_px.color.red   = m_axis_tdata[55:48];
            got_px.color.green = m_axis_tdata[63:56];
            got_px.color.blue  = m_axis_tdata[71:64];
            if (pending_pixels.size() == 0) begin
                log_error("unexpected result", '0, got_px);
            end else begin
                want_px = pending_pixels.pop_front();
                if (want_px.hit)
                    hits_seen++;
                if (got_px.hit !== want_px.hit || got_px.column !== want_px.column ||
                    got_px.row !== want_px.row || got_px.addr !== want_px.addr ||
                    got_px.color.red !== want_px.color.red ||
                    got_px.color.green !== want_px.color.green ||
                    got_px.color.blue !== want_px.color.blue)
                    log_error("wrong result", want_px, got_px);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending_pixels.size());
            $display("pinhole_point_projector: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_camera();
        test_image_edges();
        test_random_sweep();
        wait_idle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("projected %0d points over %0d camera settings, %0d of them hits",
                 items_sent, settings_used, hits_seen);
        $display("checked %0d results, %0d wrong, %0d still outstanding",
                 results_seen, errors, pending_pixels.size());
        if (errors == 0 && pending_pixels.size() == 0)
            $display("pinhole_point_projector: match");
        else
            $display("pinhole_point_projector: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
design/ppp_pkg.sv
design/ppp_front.sv
design/ppp_queue.sv
design/ppp_div.sv
design/ppp_back.sv
design/pinhole_point_projector.sv
test/tb_pinhole_point_projector.sv
